@@ rtl/rcb_pkg.sv @@
`timescale 1ns / 1ps

package rcb_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIRST    = 2'd0;
    localparam logic [1:0] CFG_SECOND   = 2'd1;
    localparam logic [1:0] CFG_INTERVAL = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int ELAPSED_W = 20;
    localparam int ACCUM_W = 32;

    localparam logic [23:0] RST_FIRST    = 24'hFF00FF;
    localparam logic [23:0] RST_SECOND   = 24'h000000;
    localparam logic [23:0] RST_INTERVAL = 24'd50000;

    localparam int STEPS_DEF = 100;

    // Per-stage advance strobes of the blend pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic so;
    } rcb_adv_t;

    // Blend operands produced by the step controller
    typedef struct packed {
        logic        emit;
        logic [23:0] from_rgb;
        logic [23:0] to_rgb;
    } rcb_op_t;

endpackage

@@ rtl/rgb_crossfade_breathing.sv @@
`timescale 1ns / 1ps
// Breathing RGB crossfade.
// Input channel: one word per timer tick carrying elapsed_us; in_valid/in_stall.
// Each tick is added to a saturating time accumulator; when it exceeds the
// interval register a fade step happens and one RGB word leaves on the output
// channel (out_valid/out_stall with red, green, blue). Ticks that leave the
// accumulator at or below the interval produce no output word.
// Configuration: cfg_we writes cfg_data to the register selected by cfg_index
// (0 first color, 1 second color, 2 interval); any valid write restarts the fade.
// Throughput: one tick per cycle while in_stall is low. A step word moves through
// the operand, product, reciprocal-multiply quotient and output registers, in
// that order, after its tick is accepted.
// Stalls: the four blend stages collapse bubbles; in_stall rises only when all
// four stages hold words and out_stall is high.
// Reset: colors return to magenta and black, interval to 50000 us, the
// accumulator and fade position clear and the pipeline empties.

module rgb_crossfade_breathing
    import rcb_pkg::*;
#(
    parameter int STEPS = STEPS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ELAPSED_W-1:0]   elapsed_us,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             red,
    output logic [7:0]             green,
    output logic [7:0]             blue
);

    localparam int PW = $clog2(STEPS + 1);

    logic          v1_reg, v2_reg, v3_reg, vo_reg;
    logic          rdy1, rdy2, rdy3, rdyo;
    logic          in_acc;
    rcb_adv_t      adv;
    rcb_op_t       op;
    logic [PW-1:0] pos;

    always_comb
    begin
        rdyo   = !vo_reg || !out_stall;
        rdy3   = !v3_reg || rdyo;
        rdy2   = !v2_reg || rdy3;
        rdy1   = !v1_reg || rdy2;
        in_acc = in_valid && rdy1;
        adv.s1 = rdy1;
        adv.s2 = rdy2;
        adv.s3 = rdy3;
        adv.so = rdyo;
    end

    assign in_stall  = !rdy1;
    assign out_valid = vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_acc && op.emit && !cfg_we;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdyo)
            begin
                vo_reg <= v3_reg;
            end
        end
    end

    rcb_ctrl #(
        .STEPS (STEPS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .acc        (in_acc),
        .elapsed_us (elapsed_us),
        .op         (op),
        .pos        (pos)
    );

    rcb_lane #(
        .STEPS (STEPS)
    ) u_lane_r (
        .clk     (clk),
        .adv     (adv),
        .from_ch (op.from_rgb[23:16]),
        .to_ch   (op.to_rgb[23:16]),
        .pos     (pos),
        .ch      (red)
    );

    rcb_lane #(
        .STEPS (STEPS)
    ) u_lane_g (
        .clk     (clk),
        .adv     (adv),
        .from_ch (op.from_rgb[15:8]),
        .to_ch   (op.to_rgb[15:8]),
        .pos     (pos),
        .ch      (green)
    );

    rcb_lane #(
        .STEPS (STEPS)
    ) u_lane_b (
        .clk     (clk),
        .adv     (adv),
        .from_ch (op.from_rgb[7:0]),
        .to_ch   (op.to_rgb[7:0]),
        .pos     (pos),
        .ch      (blue)
    );

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && vo_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !(vo_reg && out_stall)) |=> vo_reg)
        else $error("stage three word lost");

endmodule

@@ rtl/rcb_ctrl.sv @@
`timescale 1ns / 1ps

module rcb_ctrl
    import rcb_pkg::*;
#(
    parameter int STEPS = STEPS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          acc,
    input  logic [ELAPSED_W-1:0]          elapsed_us,
    output rcb_op_t                       op,
    output logic [$clog2(STEPS+1)-1:0]    pos
);

    localparam int PW = $clog2(STEPS + 1);

    logic [23:0]        first_reg, first_next;
    logic [23:0]        second_reg, second_next;
    logic [23:0]        interval_reg, interval_next;
    logic [23:0]        from_reg, from_next;
    logic [23:0]        to_reg, to_next;
    logic [ACCUM_W-1:0] accum_reg, accum_next;
    logic [PW-1:0]      pos_reg, pos_next;

    logic [ACCUM_W:0]   sum_w;
    logic [ACCUM_W-1:0] sat;
    logic               hit;
    logic [PW-1:0]      pos_inc;
    logic               wrap;
    logic               restart;

    always_comb
    begin
        sum_w   = {1'b0, accum_reg} + (ACCUM_W + 1)'(elapsed_us);
        sat     = sum_w[ACCUM_W] ? {ACCUM_W{1'b1}} : sum_w[ACCUM_W-1:0];
        hit     = sat > (ACCUM_W)'(interval_reg);
        pos_inc = pos_reg + 1'b1;
        wrap    = pos_inc >= PW'(STEPS);
    end

    always_comb
    begin
        first_next    = first_reg;
        second_next   = second_reg;
        interval_next = interval_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        accum_next    = accum_reg;
        pos_next      = pos_reg;
        restart       = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST:
                begin
                    first_next = cfg_data;
                    restart    = 1'b1;
                end
                CFG_SECOND:
                begin
                    second_next = cfg_data;
                    restart     = 1'b1;
                end
                CFG_INTERVAL:
                begin
                    interval_next = cfg_data;
                    restart       = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
            if (restart)
            begin
                from_next  = first_next;
                to_next    = second_next;
                accum_next = '0;
                pos_next   = '0;
            end
        end
        else if (acc)
        begin
            accum_next = hit ? '0 : sat;
            if (hit)
            begin
                pos_next = wrap ? '0 : pos_inc;
                // swap ends so the fade runs back the other way
                if (wrap)
                begin
                    from_next = to_reg;
                    to_next   = from_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg    <= RST_FIRST;
            second_reg   <= RST_SECOND;
            interval_reg <= RST_INTERVAL;
            from_reg     <= RST_FIRST;
            to_reg       <= RST_SECOND;
            accum_reg    <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            first_reg    <= first_next;
            second_reg   <= second_next;
            interval_reg <= interval_next;
            from_reg     <= from_next;
            to_reg       <= to_next;
            accum_reg    <= accum_next;
            pos_reg      <= pos_next;
        end
    end

    // At the last step the position equals STEPS, which blends to the to-color exactly
    assign op.emit     = hit;
    assign op.from_rgb = from_reg;
    assign op.to_rgb   = to_reg;
    assign pos         = pos_inc;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < PW'(STEPS))
        else $error("fade position out of range");

    a_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && hit && !cfg_we) |=> (accum_reg == '0))
        else $error("accumulator not cleared after step");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index <= CFG_INTERVAL) |=> (pos_reg == '0 && accum_reg == '0))
        else $error("config write did not restart fade");

endmodule

@@ rtl/rcb_lane.sv @@
`timescale 1ns / 1ps

module rcb_lane
    import rcb_pkg::*;
#(
    parameter int STEPS = STEPS_DEF
)
(
    input  logic                          clk,
    input  rcb_adv_t                      adv,
    input  logic [7:0]                    from_ch,
    input  logic [7:0]                    to_ch,
    input  logic [$clog2(STEPS+1)-1:0]    pos,
    output logic [7:0]                    ch
);

    localparam int PW   = $clog2(STEPS + 1);
    localparam int PRW  = PW + 10;
    localparam int OFS  = 255 * STEPS;
    localparam int NB   = $clog2(510 * STEPS);
    localparam int SH   = NB + $clog2(STEPS);
    localparam int MW   = NB + 2;
    localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(STEPS) - 64'd1) / 64'(STEPS);
    localparam logic [MW-1:0] RECIP_W = RECIP[MW-1:0];

    logic [7:0]              from1_reg, to1_reg;
    logic [PW-1:0]           pos1_reg;
    logic [7:0]              from2_reg, from3_reg;
    logic signed [PRW-1:0]   prod_reg, prod_next;
    logic [8:0]              q_reg, q_next;
    logic [7:0]              ch_reg;

    logic signed [8:0]       diff;
    logic signed [PW:0]      pos_s;
    logic signed [PRW:0]     nsum;
    logic [NB-1:0]           n;
    logic [NB+MW-1:0]        mul;
    logic [9:0]              sum;

    always_comb
    begin
        diff      = $signed({1'b0, to1_reg}) - $signed({1'b0, from1_reg});
        pos_s     = $signed({1'b0, pos1_reg});
        prod_next = diff * pos_s;
        // bias to nonnegative so the floor division becomes unsigned
        nsum      = (PRW + 1)'(prod_reg) + (PRW + 1)'(OFS);
        n         = nsum[NB-1:0];
        mul       = (NB + MW)'(n) * (NB + MW)'(RECIP_W);
        q_next    = mul[SH+8:SH];
        sum       = {2'b00, from3_reg} + {1'b0, q_reg} - 10'd255;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            from1_reg <= from_ch;
            to1_reg   <= to_ch;
            pos1_reg  <= pos;
        end
        if (adv.s2)
        begin
            prod_reg  <= prod_next;
            from2_reg <= from1_reg;
        end
        if (adv.s3)
        begin
            q_reg     <= q_next;
            from3_reg <= from2_reg;
        end
        if (adv.so)
        begin
            ch_reg <= sum[7:0];
        end
    end

    assign ch = ch_reg;

endmodule
